>>> hw/rtl/lru_ol_pkg.sv
package lru_ol_pkg;

    localparam int ENTRIES   = 16;
    localparam int SLOT_BITS = 4;
    localparam int TAG_BITS  = 32;
    localparam int CNT_BITS  = 5;
    localparam int CAP_BITS  = 5;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(ENTRIES);

    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [CNT_BITS-1:0]  count_t;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_TOUCH  = 2'd1,
        ACT_EVICT  = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_MISSING = 2'd2
    } status_t;

    // One write per link table per cycle
    typedef struct packed {
        logic  next_we;
        slot_t next_addr;
        slot_t next_data;
        logic  prev_we;
        slot_t prev_addr;
        slot_t prev_data;
    } link_wr_t;

    // Lowest slot whose valid bit is clear
    function automatic slot_t lowest_free(input logic [ENTRIES-1:0] valid);
        slot_t s;
        s = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid[i]) begin
                s = slot_t'(i);
            end
        end
        return s;
    endfunction

endpackage

>>> hw/rtl/lru_order_list.sv
// LRU order list: keeps up to capacity_in_use slots (1..16, 0 acts as 1, larger
// values as 16) in most-recently-used order as a doubly linked list, each slot
// with a 32-bit tag. A request is taken at a clock edge where start is high and
// busy is low. Exactly one result follows per request, shown for one cycle with
// done high; the receiver cannot stall it, so capture it on that cycle. Requests
// that change nothing (empty list, slot not in list, touch of the head) report
// on the next cycle and never raise busy; insert into a list with room passes
// through the link state only, evict and remove through the unlink state only,
// insert that evicts the tail and touch through unlink and then link. The steps
// are set by the link tables: one pass reads the victim's links and
// tag and unlinks it, one pass links the slot at the head, each table taking one
// write per cycle. A new request may be taken on the same cycle that done is
// high. Write capacity_in_use on the cfg channel only while the block is idle;
// cfg_ready is always high.
module lru_order_list
    import lru_ol_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // request transaction
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          action,
    input  logic [SLOT_BITS-1:0] target_slot,
    input  logic [TAG_BITS-1:0] new_tag,
    // configuration
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CAP_BITS-1:0] cfg_data,
    // result transaction
    output logic                done,
    output logic [1:0]          status,
    output logic [SLOT_BITS-1:0] result_slot,
    output logic                evicted,
    output logic [TAG_BITS-1:0] old_tag,
    output logic [SLOT_BITS-1:0] head_now,
    output logic [SLOT_BITS-1:0] tail_now,
    output logic [CNT_BITS-1:0] count_now
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_UNLINK = 3'b010,
        S_LINK   = 3'b100
    } state_t;

    state_t                state_reg,   state_next;
    action_t               act_reg,     act_next;
    slot_t                 slot_reg,    slot_next;
    logic [TAG_BITS-1:0]   tag_in_reg,  tag_in_next;
    logic                  evict_reg,   evict_next;
    logic [TAG_BITS-1:0]   old_tag_reg, old_tag_next;
    logic [CAP_BITS-1:0]   cap_reg,     cap_next;
    slot_t                 head_reg,    head_next;
    slot_t                 tail_reg,    tail_next;
    count_t                count_reg,   count_next;
    logic [ENTRIES-1:0]    valid_reg,   valid_next;

    // result registers
    logic                  done_reg,    done_next;
    status_t               stat_o_reg,  stat_o_next;
    slot_t                 slot_o_reg,  slot_o_next;
    logic                  ev_o_reg,    ev_o_next;
    logic [TAG_BITS-1:0]   tag_o_reg,   tag_o_next;
    slot_t                 head_o_reg,  head_o_next;
    slot_t                 tail_o_reg,  tail_o_next;
    count_t                count_o_reg, count_o_next;

    logic [TAG_BITS-1:0]   tag_mem [ENTRIES];
    logic [TAG_BITS-1:0]   tag_rd_reg;
    logic                  tag_we;
    slot_t                 tag_waddr;

    link_wr_t              link_wr;
    slot_t                 rd_addr;
    slot_t                 next_rd;
    slot_t                 prev_rd;

    action_t               act_in;
    logic                  accept;
    count_t                eff_cap;
    logic                  full;
    slot_t                 link_slot;

    logic                  fin;
    status_t               fin_stat;
    slot_t                 fin_slot;
    logic                  fin_ev;
    logic [TAG_BITS-1:0]   fin_tag;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign act_in    = action_t'(action);

    // Effective capacity: clamp to 1..ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = count_t'(1);
        end
        else if (CNT_BITS'(cap_reg) > count_t'(ENTRIES))
        begin
            eff_cap = count_t'(ENTRIES);
        end
        else
        begin
            eff_cap = CNT_BITS'(cap_reg);
        end
    end

    assign full = (count_reg >= eff_cap) && (count_reg != '0);

    // Victim for insert and evict is the tail, else the named slot
    assign rd_addr = (act_in == ACT_INSERT || act_in == ACT_EVICT) ? tail_reg : target_slot;

    assign link_slot = (act_reg == ACT_INSERT) ? lowest_free(valid_reg) : slot_reg;

    lru_ol_links u_links (
        .clk     (clk),
        .wr      (link_wr),
        .rd_addr (rd_addr),
        .next_rd (next_rd),
        .prev_rd (prev_rd)
    );

    // Tag store, registered read
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_in_reg;
        end
        tag_rd_reg <= tag_mem[rd_addr];
    end

    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        slot_next    = slot_reg;
        tag_in_next  = tag_in_reg;
        evict_next   = evict_reg;
        old_tag_next = old_tag_reg;
        cap_next     = cap_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        valid_next   = valid_reg;
        link_wr      = '0;
        tag_we       = 1'b0;
        tag_waddr    = link_slot;
        fin          = 1'b0;
        fin_stat     = STAT_OK;
        fin_slot     = '0;
        fin_ev       = 1'b0;
        fin_tag      = '0;

        if (cfg_valid && cfg_ready)
        begin
            cap_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next    = act_in;
                    slot_next   = rd_addr;
                    tag_in_next = new_tag;
                    evict_next  = (act_in == ACT_INSERT) && full;
                    unique case (act_in) inside
                        ACT_INSERT:
                        begin
                            state_next = full ? S_UNLINK : S_LINK;
                        end
                        ACT_EVICT:
                        begin
                            if (count_reg == '0)
                            begin
                                fin      = 1'b1;
                                fin_stat = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_UNLINK;
                            end
                        end
                        ACT_TOUCH, ACT_REMOVE:
                        begin
                            fin_slot = target_slot;
                            if (count_reg == '0)
                            begin
                                fin      = 1'b1;
                                fin_stat = STAT_EMPTY;
                            end
                            else if (!valid_reg[target_slot])
                            begin
                                fin      = 1'b1;
                                fin_stat = STAT_MISSING;
                            end
                            else if (act_in == ACT_TOUCH && target_slot == head_reg)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                state_next = S_UNLINK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_UNLINK:
            begin
                // Drop the victim from the chain
                if (count_reg <= count_t'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else if (slot_reg == head_reg)
                begin
                    head_next = next_rd;
                end
                else if (slot_reg == tail_reg)
                begin
                    tail_next = prev_rd;
                end
                else
                begin
                    link_wr.next_we   = 1'b1;
                    link_wr.next_addr = prev_rd;
                    link_wr.next_data = next_rd;
                    link_wr.prev_we   = 1'b1;
                    link_wr.prev_addr = next_rd;
                    link_wr.prev_data = prev_rd;
                end
                valid_next[slot_reg] = 1'b0;
                count_next           = count_reg - count_t'(1);
                old_tag_next         = tag_rd_reg;
                if (act_reg == ACT_INSERT || act_reg == ACT_TOUCH)
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    state_next = S_IDLE;
                    fin        = 1'b1;
                    fin_slot   = slot_reg;
                    fin_ev     = 1'b1;
                    fin_tag    = tag_rd_reg;
                end
            end

            S_LINK:
            begin
                // Put the slot at the head
                if (count_reg == '0)
                begin
                    head_next = link_slot;
                    tail_next = link_slot;
                end
                else
                begin
                    link_wr.next_we   = 1'b1;
                    link_wr.next_addr = link_slot;
                    link_wr.next_data = head_reg;
                    link_wr.prev_we   = 1'b1;
                    link_wr.prev_addr = head_reg;
                    link_wr.prev_data = link_slot;
                    head_next         = link_slot;
                end
                valid_next[link_slot] = 1'b1;
                count_next            = count_reg + count_t'(1);
                tag_we                = (act_reg == ACT_INSERT);
                state_next            = S_IDLE;
                fin                   = 1'b1;
                fin_slot              = link_slot;
                fin_ev                = evict_reg;
                fin_tag               = evict_reg ? old_tag_reg : '0;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Load the result from the state after the step
        done_next    = fin;
        stat_o_next  = stat_o_reg;
        slot_o_next  = slot_o_reg;
        ev_o_next    = ev_o_reg;
        tag_o_next   = tag_o_reg;
        head_o_next  = head_o_reg;
        tail_o_next  = tail_o_reg;
        count_o_next = count_o_reg;
        if (fin)
        begin
            stat_o_next  = fin_stat;
            slot_o_next  = fin_slot;
            ev_o_next    = fin_ev;
            tag_o_next   = fin_tag;
            head_o_next  = (count_next != '0) ? head_next : '0;
            tail_o_next  = (count_next != '0) ? tail_next : '0;
            count_o_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cap_reg   <= CAP_RESET;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    // Request and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        slot_reg    <= slot_next;
        tag_in_reg  <= tag_in_next;
        evict_reg   <= evict_next;
        old_tag_reg <= old_tag_next;
        stat_o_reg  <= stat_o_next;
        slot_o_reg  <= slot_o_next;
        ev_o_reg    <= ev_o_next;
        tag_o_reg   <= tag_o_next;
        head_o_reg  <= head_o_next;
        tail_o_reg  <= tail_o_next;
        count_o_reg <= count_o_next;
    end

    assign done        = done_reg;
    assign status      = stat_o_reg;
    assign result_slot = slot_o_reg;
    assign evicted     = ev_o_reg;
    assign old_tag     = tag_o_reg;
    assign head_now    = head_o_reg;
    assign tail_now    = tail_o_reg;
    assign count_now   = count_o_reg;

    // Valid bits and the entry count must agree
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == count_reg)
        else $error("entry count disagrees with valid bits");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(ENTRIES))
        else $error("entry count above table size");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> head_reg == '0 && tail_reg == '0)
        else $error("empty list with nonzero head or tail");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done_reg || busy)
        else $error("accepted request neither finished nor in progress");

    a_link_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LINK |=> done_reg && state_reg == S_IDLE)
        else $error("link pass did not complete the request");

endmodule

>>> hw/rtl/lru_ol_links.sv
module lru_ol_links
    import lru_ol_pkg::*;
(
    input  logic     clk,
    input  link_wr_t wr,
    input  slot_t    rd_addr,
    output slot_t    next_rd,
    output slot_t    prev_rd
);

    slot_t next_mem [ENTRIES];
    slot_t prev_mem [ENTRIES];
    slot_t next_rd_reg;
    slot_t prev_rd_reg;

    // Write when enabled, read registered; a read of a written address sees the old data
    always_ff @(posedge clk)
    begin
        if (wr.next_we)
        begin
            next_mem[wr.next_addr] <= wr.next_data;
        end
        next_rd_reg <= next_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.prev_we)
        begin
            prev_mem[wr.prev_addr] <= wr.prev_data;
        end
        prev_rd_reg <= prev_mem[rd_addr];
    end

    assign next_rd = next_rd_reg;
    assign prev_rd = prev_rd_reg;

endmodule
